FILE: rtl/core/spq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Status codes, operation kinds and the control word broadcast to the cells.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 5;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_TAKE   = 1'b1;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_TAKEN     = 3'd3,
        ST_EMPTY     = 3'd4
    } status_t;

    // broadcast to every cell in the cycle a word is accepted
    typedef struct packed {
        logic                       ins;   // insert goes ahead
        logic                       take;  // head is removed
        logic signed [VALUE_W-1:0]  value;
    } cell_ctl_t;

endpackage
`default_nettype wire

FILE: rtl/core/spq_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one entry; keeps it, takes the new value, or takes a neighbour's entry.
// ----------------------------------------------------------------------------
module spq_cell
(
    input  wire logic                                 clk,
    input  wire spq_pkg::cell_ctl_t                   ctl,
    input  wire logic                                 own_valid,
    input  wire logic                                 left_lt,
    input  wire logic signed [spq_pkg::VALUE_W-1:0]   left_val,
    input  wire logic signed [spq_pkg::VALUE_W-1:0]   right_val,
    output logic signed [spq_pkg::VALUE_W-1:0]        val,
    output logic                                      lt,
    output logic                                      eq
);

    logic signed [spq_pkg::VALUE_W-1:0] val_reg;
    logic signed [spq_pkg::VALUE_W-1:0] val_next;

    assign lt  = own_valid && (val_reg < ctl.value);
    assign eq  = own_valid && (val_reg == ctl.value);
    assign val = val_reg;

    always_comb
    begin
        val_next = val_reg;
        if (ctl.take)
        begin
            val_next = right_val;
        end
        else if (ctl.ins && !lt)
        begin
            // first cell not below the new value is its slot; the rest shift up
            if (left_lt)
            begin
                val_next = ctl.value;
            end
            else
            begin
                val_next = left_val;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule
`default_nettype wire

FILE: rtl/core/sorted_priority_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted priority queue
// Bounded ascending store of signed 32-bit values built as a row of cells.
// ----------------------------------------------------------------------------
// Use: drive a word on the input channel (kind, value) with in_valid; it is
// taken at an edge where in_stall is low. kind 0 inserts value at its sorted
// place (ignored if already held, rejected when full); kind 1 removes the
// smallest entry. Every input word yields one output word (status,
// taken_value, count) on the output channel, taken where out_stall is low.
// The result is registered: it sits in the output register the cycle after
// acceptance. Throughput is one word per cycle while the receiver does not
// stall; all cells compare against the new value at once and shift in the same
// edge, so the compare and shift across the row is what fixes the cycle.
// When the receiver stalls, the held result blocks the input channel through
// in_stall until it is taken; no word is lost or repeated.
// Reset empties the store (count 0) and clears the output valid; the entry
// values themselves are not cleared, since only entries below the count are
// ever read.
// ----------------------------------------------------------------------------
module sorted_priority_queue
#(
    parameter int CAPACITY = 16
)
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic                                 kind,
    input  wire logic signed [spq_pkg::VALUE_W-1:0]   value,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic [2:0]                                status,
    output logic signed [spq_pkg::VALUE_W-1:0]        taken_value,
    output logic [spq_pkg::COUNT_W-1:0]               count
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic                                   in_acc;
    logic                                   is_take;
    logic                                   empty;
    logic                                   full;
    logic                                   dup;
    logic                                   go_ins;
    logic                                   go_take;
    spq_pkg::cell_ctl_t                     ctl;

    logic [CAPACITY-1:0]                    cvalid;
    logic [CAPACITY-1:0]                    clt;
    logic [CAPACITY-1:0]                    ceq;
    logic signed [spq_pkg::VALUE_W-1:0]     cval [CAPACITY];

    logic [CW-1:0]                          occ_reg;
    logic [CW-1:0]                          occ_next;
    logic                                   out_valid_reg;
    logic                                   out_valid_next;
    spq_pkg::status_t                       status_reg;
    spq_pkg::status_t                       status_next;
    logic signed [spq_pkg::VALUE_W-1:0]     taken_reg;
    logic signed [spq_pkg::VALUE_W-1:0]     taken_next;
    logic [CW+spq_pkg::COUNT_W-1:0]         count_ext;

    assign in_stall = out_valid_reg && out_stall;
    assign in_acc   = in_valid && !in_stall;
    assign is_take  = (kind == spq_pkg::KIND_TAKE);
    assign empty    = (occ_reg == '0);
    assign full     = (occ_reg == CW'(CAPACITY));
    assign dup      = |ceq;
    assign go_ins   = in_acc && !is_take && !dup && !full;
    assign go_take  = in_acc && is_take && !empty;

    assign ctl.ins   = go_ins;
    assign ctl.take  = go_take;
    assign ctl.value = value;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic                               l_lt;
            logic signed [spq_pkg::VALUE_W-1:0] l_val;
            logic signed [spq_pkg::VALUE_W-1:0] r_val;

            assign cvalid[gi] = (occ_reg > CW'(gi));

            if (gi == 0)
            begin : g_first
                assign l_lt  = 1'b1;
                assign l_val = value;
            end
            else
            begin : g_mid
                assign l_lt  = clt[gi-1];
                assign l_val = cval[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign r_val = cval[gi];
            end
            else
            begin : g_inner
                assign r_val = cval[gi+1];
            end

            spq_cell u_cell
            (
                .clk       (clk),
                .ctl       (ctl),
                .own_valid (cvalid[gi]),
                .left_lt   (l_lt),
                .left_val  (l_val),
                .right_val (r_val),
                .val       (cval[gi]),
                .lt        (clt[gi]),
                .eq        (ceq[gi])
            );
        end
    endgenerate

    always_comb
    begin
        occ_next       = occ_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        taken_next     = taken_reg;
        if (in_acc)
        begin
            out_valid_next = 1'b1;
            taken_next     = '0;
            if (is_take)
            begin
                if (empty)
                begin
                    status_next = spq_pkg::ST_EMPTY;
                end
                else
                begin
                    status_next = spq_pkg::ST_TAKEN;
                    taken_next  = cval[0];
                    occ_next    = occ_reg - CW'(1);
                end
            end
            else if (dup)
            begin
                status_next = spq_pkg::ST_DUPLICATE;
            end
            else if (full)
            begin
                status_next = spq_pkg::ST_FULL;
            end
            else
            begin
                status_next = spq_pkg::ST_INSERTED;
                occ_next    = occ_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        taken_reg  <= taken_next;
    end

    assign count_ext   = {{spq_pkg::COUNT_W{1'b0}}, occ_reg};
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign taken_value = taken_reg;
    assign count       = count_ext[spq_pkg::COUNT_W-1:0];

    // occupancy never runs past the row
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CW'(CAPACITY))
        else $error("occupancy beyond capacity");

    // take on an empty store reports empty and leaves it empty
    a_empty_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && is_take && empty |=>
            status_reg == spq_pkg::ST_EMPTY && occ_reg == '0)
        else $error("empty take mishandled");

    // an insert never grows a full store
    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && !is_take && full |=> $stable(occ_reg))
        else $error("full store grew");

    // a stalled result is held until the receiver takes it
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> out_valid_reg && $stable(status_reg))
        else $error("stalled result lost");

    generate
        if (CAPACITY > 1)
        begin : g_order_chk
            // head stays strictly below its neighbour
            a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
                occ_reg >= CW'(2) |-> cval[0] < cval[1])
                else $error("head out of order");
        end
    endgenerate

endmodule
`default_nettype wire

FILE: bench/tb_sorted_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue testbench
// A table of directed words runs first: empty take, both value extremes, a
// duplicate, a fill to capacity, a rejected insert and a duplicate on the full
// store. Random traffic follows, in phases that lean towards filling, draining
// or neither. Each result is checked against an exact row or a shadow store.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue;

    localparam int CAPACITY   = 16;
    localparam int N_RANDOM   = 1500;
    localparam int QUIET_TAIL = 200;
    localparam int LIMIT      = 300000;

    typedef struct packed {
        spq_pkg::status_t                   status;
        logic signed [spq_pkg::VALUE_W-1:0] taken;
        logic [spq_pkg::COUNT_W-1:0]        count;
    } spq_result_t;

    typedef struct packed {
        logic                               k;
        logic signed [spq_pkg::VALUE_W-1:0] v;
        logic                               exact;
        spq_result_t                        res;
    } stim_row_t;

    logic                               clk = 1'b0;
    logic                               rst_n;
    logic                               in_valid;
    logic                               in_stall;
    logic                               kind;
    logic signed [spq_pkg::VALUE_W-1:0] value;
    logic                               out_valid;
    logic                               out_stall;
    logic [2:0]                         status;
    logic signed [spq_pkg::VALUE_W-1:0] taken_value;
    logic [spq_pkg::COUNT_W-1:0]        count;

    bit                                 quiet = 1'b0;
    logic                               cur_exact = 1'b0;
    spq_result_t                        cur_exp = '0;
    int                                 errors = 0;
    int                                 cycles = 0;

    spq_result_t                        awaited_results[$];
    stim_row_t                          directed_rows[$];

    logic signed [spq_pkg::VALUE_W-1:0] shadow_entries [CAPACITY];
    int                                 shadow_count = 0;

    sorted_priority_queue #(.CAPACITY(CAPACITY)) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .taken_value (taken_value),
        .count       (count)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Shadow store: apply one word and return the result it should give
    function automatic spq_result_t spq_apply(logic k,
                                              logic signed [spq_pkg::VALUE_W-1:0] v);
        spq_result_t r;
        int pos;
        r = '0;
        if (k == spq_pkg::KIND_INSERT)
        begin
            pos = 0;
            while (pos < shadow_count && shadow_entries[pos] < v)
                pos++;
            if (pos < shadow_count && shadow_entries[pos] == v)
                r.status = spq_pkg::ST_DUPLICATE;
            else if (shadow_count >= CAPACITY)
                r.status = spq_pkg::ST_FULL;
            else
            begin
                for (int j = shadow_count; j > pos; j--)
                    shadow_entries[j] = shadow_entries[j-1];
                shadow_entries[pos] = v;
                shadow_count++;
                r.status = spq_pkg::ST_INSERTED;
            end
        end
        else if (shadow_count == 0)
            r.status = spq_pkg::ST_EMPTY;
        else
        begin
            r.taken = shadow_entries[0];
            for (int j = 1; j < shadow_count; j++)
                shadow_entries[j-1] = shadow_entries[j];
            shadow_count--;
            r.status = spq_pkg::ST_TAKEN;
        end
        r.count = spq_pkg::COUNT_W'(shadow_count);
        return r;
    endfunction

    // Everything is sampled mid-cycle, away from the driving edge
    always @(negedge clk)
    begin : monitor
        spq_result_t want;
        spq_result_t pred;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("result word with none outstanding: status %0d", status);
                    errors++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (want.status !== status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        errors++;
                    end
                    if (want.taken !== taken_value)
                    begin
                        $error("taken_value: expected %0d, got %0d", want.taken, taken_value);
                        errors++;
                    end
                    if (want.count !== count)
                    begin
                        $error("count: expected %0d, got %0d", want.count, count);
                        errors++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                pred = spq_apply(kind, value);
                awaited_results.push_back(cur_exact ? cur_exp : pred);
            end
        end
    end

    task automatic add_row(input logic k, input logic signed [spq_pkg::VALUE_W-1:0] v,
                           input logic exact, input spq_pkg::status_t st,
                           input logic signed [spq_pkg::VALUE_W-1:0] tv, input int cnt);
        stim_row_t r;
        r.k = k;
        r.v = v;
        r.exact = exact;
        r.res.status = st;
        r.res.taken = tv;
        r.res.count = spq_pkg::COUNT_W'(cnt);
        directed_rows.push_back(r);
    endtask

    // Called at a rising edge; returns at the edge where the word is taken
    task automatic send_word(input logic k, input logic signed [spq_pkg::VALUE_W-1:0] v,
                             input logic exact, input spq_result_t er);
        logic got;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        kind      <= k;
        value     <= v;
        cur_exact = exact;
        cur_exp   = er;
        do
        begin
            @(negedge clk);
            got = !in_stall;
            @(posedge clk);
        end
        while (!got);
    endtask

    initial
    begin : out_side
        out_stall = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (!quiet && $urandom_range(0, 2) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    initial
    begin : in_side
        int                                 ins_pct;
        logic                               k;
        logic signed [spq_pkg::VALUE_W-1:0] v;
        logic signed [spq_pkg::VALUE_W-1:0] base;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        kind     = spq_pkg::KIND_INSERT;
        value    = '0;
        ins_pct  = 50;
        base     = '0;

        add_row(spq_pkg::KIND_TAKE,   32'sh0000_0000, 1'b1, spq_pkg::ST_EMPTY,     32'sh0, 0);
        add_row(spq_pkg::KIND_INSERT, 32'sh7FFF_FFFF, 1'b1, spq_pkg::ST_INSERTED,  32'sh0, 1);
        add_row(spq_pkg::KIND_INSERT, 32'sh8000_0000, 1'b1, spq_pkg::ST_INSERTED,  32'sh0, 2);
        add_row(spq_pkg::KIND_INSERT, 32'sh7FFF_FFFF, 1'b1, spq_pkg::ST_DUPLICATE, 32'sh0, 2);
        // value on a take is don't-care
        add_row(spq_pkg::KIND_TAKE, 32'shFFFF_FFFF, 1'b1, spq_pkg::ST_TAKEN,
                32'sh8000_0000, 1);
        add_row(spq_pkg::KIND_TAKE, 32'sh0000_0000, 1'b1, spq_pkg::ST_TAKEN,
                32'sh7FFF_FFFF, 0);
        // fill to capacity, mixed order
        add_row(spq_pkg::KIND_INSERT, 32'sh0000_0000, 1'b0, spq_pkg::ST_INSERTED, 32'sh0, 0);
        add_row(spq_pkg::KIND_INSERT, 32'shFFFF_FFFF, 1'b0, spq_pkg::ST_INSERTED, 32'sh0, 0);
        add_row(spq_pkg::KIND_INSERT, 32'sh0000_0001, 1'b0, spq_pkg::ST_INSERTED, 32'sh0, 0);
        add_row(spq_pkg::KIND_INSERT, 32'sh5555_5555, 1'b0, spq_pkg::ST_INSERTED, 32'sh0, 0);
        add_row(spq_pkg::KIND_INSERT, 32'shAAAA_AAAA, 1'b0, spq_pkg::ST_INSERTED, 32'sh0, 0);
        add_row(spq_pkg::KIND_INSERT, 32'sh8000_0000, 1'b0, spq_pkg::ST_INSERTED, 32'sh0, 0);
        add_row(spq_pkg::KIND_INSERT, 32'sh7FFF_FFFF, 1'b0, spq_pkg::ST_INSERTED, 32'sh0, 0);
        add_row(spq_pkg::KIND_INSERT, 32'sh0001_0000, 1'b0, spq_pkg::ST_INSERTED, 32'sh0, 0);
        add_row(spq_pkg::KIND_INSERT, 32'shFFFF_0000, 1'b0, spq_pkg::ST_INSERTED, 32'sh0, 0);
        add_row(spq_pkg::KIND_INSERT, 32'sh1234_5678, 1'b0, spq_pkg::ST_INSERTED, 32'sh0, 0);
        add_row(spq_pkg::KIND_INSERT, 32'shEDCB_A987, 1'b0, spq_pkg::ST_INSERTED, 32'sh0, 0);
        add_row(spq_pkg::KIND_INSERT, 32'sh4000_0000, 1'b0, spq_pkg::ST_INSERTED, 32'sh0, 0);
        add_row(spq_pkg::KIND_INSERT, 32'shC000_0000, 1'b0, spq_pkg::ST_INSERTED, 32'sh0, 0);
        add_row(spq_pkg::KIND_INSERT, 32'sh0000_0100, 1'b0, spq_pkg::ST_INSERTED, 32'sh0, 0);
        add_row(spq_pkg::KIND_INSERT, 32'shFFFF_FF00, 1'b0, spq_pkg::ST_INSERTED, 32'sh0, 0);
        add_row(spq_pkg::KIND_INSERT, 32'sh3C3C_3C3C, 1'b0, spq_pkg::ST_INSERTED, 32'sh0, 0);
        // full: new value bounced, held value still reads as duplicate
        add_row(spq_pkg::KIND_INSERT, 32'sh0000_0002, 1'b1, spq_pkg::ST_FULL,      32'sh0, 16);
        add_row(spq_pkg::KIND_INSERT, 32'sh8000_0000, 1'b1, spq_pkg::ST_DUPLICATE, 32'sh0, 16);
        add_row(spq_pkg::KIND_TAKE, 32'sh7FFF_FFFF, 1'b1, spq_pkg::ST_TAKEN,
                32'sh8000_0000, 15);
        add_row(spq_pkg::KIND_TAKE, 32'sh0000_0000, 1'b0, spq_pkg::ST_TAKEN, 32'sh0, 0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_word(directed_rows[i].k, directed_rows[i].v,
                      directed_rows[i].exact, directed_rows[i].res);

        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i % 48 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       ins_pct = 90;
                    1:       ins_pct = 50;
                    default: ins_pct = 15;
                endcase
                base = $urandom;
            end
            if (i == N_RANDOM / 2)
            begin
                // let the pipe drain completely once
                in_valid <= 1'b0;
                while (awaited_results.size() != 0)
                    @(posedge clk);
                @(posedge clk);
            end
            if (i == N_RANDOM - QUIET_TAIL)
                quiet = 1'b1;
            k = ($urandom_range(0, 99) < ins_pct) ? spq_pkg::KIND_INSERT : spq_pkg::KIND_TAKE;
            case ($urandom_range(0, 9))
                0, 1, 2, 3: v = $signed($urandom_range(0, 32)) - 16;
                4, 5, 6:    v = $urandom;
                7:
                begin
                    case ($urandom_range(0, 3))
                        0:       v = 32'sh8000_0000;
                        1:       v = 32'sh7FFF_FFFF;
                        2:       v = 32'sh0000_0000;
                        default: v = 32'shFFFF_FFFF;
                    endcase
                end
                default:    v = base + $urandom_range(0, 7);
            endcase
            send_word(k, v, 1'b0, '0);
        end

        in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
